// ===== hdl/faps_pkg.sv =====
// Package for the four-axis permute/scatter address generator.
// Holds field widths, register indexes, the axis order table, the front-end status type and width helpers.
// No dependencies; every other file in hdl/ but faps_queue uses it.
`timescale 1ns / 1ps

package faps_pkg;

    localparam int NUM_AXES       = 4;
    localparam int ELEM_W         = 64;
    localparam int OFFS_W         = 20;
    localparam int EXT_RAW_W      = 6;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int MAX_EXTENT_DEF = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_ONE   = 3'd0,
        REG_EXTENT_TWO   = 3'd1,
        REG_EXTENT_THREE = 3'd2,
        REG_EXTENT_FOUR  = 3'd3,
        REG_PERM_MODE    = 3'd4
    } t_reg_idx;

    // Target axis order, slowest axis at position 0
    typedef logic [0:NUM_AXES-1][1:0] t_order;

    // Status of the front end, for checks at the top level
    typedef struct packed {
        logic at_first;   // counters point at the first element
        logic at_last;    // counters point at the final element
    } t_front_stat;

    // Counter width for a given largest extent
    function automatic int cnt_width(input int max_ext);
        return (max_ext > 1) ? $clog2(max_ext) : 1;
    endfunction

    // Width that holds an extent value up to max_ext
    function automatic int ext_width(input int max_ext);
        return (max_ext > 1) ? $clog2(max_ext + 1) : 1;
    endfunction

    // Source axis for each target position, by mode
    function automatic t_order axis_order(input logic [MODE_W-1:0] mode);
        t_order ord;
        case (mode)
            3'd0:    ord = '{2'd0, 2'd1, 2'd3, 2'd2};
            3'd1:    ord = '{2'd0, 2'd1, 2'd3, 2'd2};
            3'd2:    ord = '{2'd1, 2'd0, 2'd2, 2'd3};
            3'd3:    ord = '{2'd1, 2'd0, 2'd3, 2'd2};
            3'd4:    ord = '{2'd2, 2'd3, 2'd0, 2'd1};
            3'd5:    ord = '{2'd2, 2'd3, 2'd1, 2'd0};
            3'd6:    ord = '{2'd3, 2'd2, 2'd0, 2'd1};
            default: ord = '{2'd3, 2'd2, 2'd1, 2'd0};
        endcase
        return ord;
    endfunction

endpackage

// ===== hdl/faps_if.sv =====
// Channel interfaces: element input, result output and configuration write.
// Depends on faps_pkg for field widths.
`timescale 1ns / 1ps

interface faps_in_if;
    logic                       valid;
    logic                       ready;
    logic [faps_pkg::ELEM_W-1:0] elem_in;

    modport source (output valid, output elem_in, input ready);
    modport sink   (input valid, input elem_in, output ready);
endinterface

interface faps_out_if;
    logic                        valid;
    logic                        ready;
    logic [faps_pkg::ELEM_W-1:0] elem_out;
    logic [faps_pkg::OFFS_W-1:0] dest_offset;
    logic                        is_last;

    modport source (output valid, output elem_out, output dest_offset, output is_last,
                    input ready);
    modport sink   (input valid, input elem_out, input dest_offset, input is_last,
                    output ready);
endinterface

interface faps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [faps_pkg::CFG_IDX_W-1:0] index;
    logic [faps_pkg::EXT_RAW_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/faps_front.sv =====
// Front end: configuration registers, source index counters and axis permutation.
// Emits one job per accepted item; depends on faps_pkg and faps_if.
`timescale 1ns / 1ps

module faps_front #(
    parameter int MAX_EXTENT = faps_pkg::MAX_EXTENT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    faps_cfg_if.sink                i_cfg,
    faps_in_if.sink                 i_in,
    output logic                    o_job_valid,
    input  logic                    i_job_ready,
    output logic [faps_pkg::ELEM_W + 1
                  + faps_pkg::NUM_AXES * faps_pkg::cnt_width(MAX_EXTENT)
                  + (faps_pkg::NUM_AXES - 1) * faps_pkg::ext_width(MAX_EXTENT) - 1:0] o_job,
    output faps_pkg::t_front_stat   o_stat
);

    localparam int CW = faps_pkg::cnt_width(MAX_EXTENT);
    localparam int EW = faps_pkg::ext_width(MAX_EXTENT);
    localparam int NA = faps_pkg::NUM_AXES;
    localparam logic [faps_pkg::EXT_RAW_W:0] MAX_X = (faps_pkg::EXT_RAW_W + 1)'(MAX_EXTENT);

    logic [faps_pkg::EXT_RAW_W-1:0] r_ext_raw [NA];
    logic [faps_pkg::MODE_W-1:0]    r_mode;
    logic [CW-1:0]                  r_cnt     [NA];
    logic [CW-1:0]                  n_cnt     [NA];

    logic [EW-1:0]       eff     [NA];
    logic [NA-1:0]       at_end;
    logic [NA:0]         carry;
    logic                cfg_wr;
    logic                cfg_ext;
    logic                accept;
    faps_pkg::t_order    ord;
    logic [CW-1:0]       y       [NA];
    logic [EW-1:0]       m       [NA];

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign cfg_ext     = i_cfg.index inside {faps_pkg::REG_EXTENT_ONE, faps_pkg::REG_EXTENT_TWO,
                                             faps_pkg::REG_EXTENT_THREE,
                                             faps_pkg::REG_EXTENT_FOUR};

    assign o_job_valid = i_in.valid;
    assign i_in.ready  = i_job_ready;
    assign accept      = i_in.valid & i_job_ready;

    // Clamp extents and flag axes at their final index
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (r_ext_raw[i] == '0) begin
                eff[i] = EW'(1);
            end else if ({1'b0, r_ext_raw[i]} > MAX_X) begin
                eff[i] = EW'(MAX_EXTENT);
            end else begin
                eff[i] = EW'(r_ext_raw[i]);
            end
            at_end[i] = ((EW + 1)'(r_cnt[i]) + (EW + 1)'(1)) >= (EW + 1)'(eff[i]);
        end
    end

    // Advance the odometer, fourth axis fastest
    always_comb begin
        carry[NA] = 1'b1;
        for (int i = NA - 1; i >= 0; i--) begin
            if (carry[i + 1]) begin
                n_cnt[i] = at_end[i] ? '0 : r_cnt[i] + CW'(1);
            end else begin
                n_cnt[i] = r_cnt[i];
            end
            carry[i] = carry[i + 1] & at_end[i];
        end
    end

    // Reorder indices and extents into target axis order
    always_comb begin
        ord = faps_pkg::axis_order(r_mode);
        for (int p = 0; p < NA; p++) begin
            y[p] = r_cnt[ord[p]];
            m[p] = eff[ord[p]];
        end
    end

    assign o_job = {i_in.elem_in, &at_end, y[0], y[1], y[2], y[3], m[1], m[2], m[3]};

    assign o_stat.at_first = (r_cnt[0] == '0) && (r_cnt[1] == '0)
                           && (r_cnt[2] == '0) && (r_cnt[3] == '0);
    assign o_stat.at_last  = &at_end;

    // Hold configuration; extent writes restart the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NA; i++) begin
                r_ext_raw[i] <= faps_pkg::EXT_RAW_W'(1);
                r_cnt[i]     <= '0;
            end
            r_mode <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                faps_pkg::REG_EXTENT_ONE:   r_ext_raw[0] <= i_cfg.data;
                faps_pkg::REG_EXTENT_TWO:   r_ext_raw[1] <= i_cfg.data;
                faps_pkg::REG_EXTENT_THREE: r_ext_raw[2] <= i_cfg.data;
                faps_pkg::REG_EXTENT_FOUR:  r_ext_raw[3] <= i_cfg.data;
                faps_pkg::REG_PERM_MODE:    r_mode <= i_cfg.data[faps_pkg::MODE_W-1:0];
                default: ;
            endcase
            if (cfg_ext) begin
                for (int i = 0; i < NA; i++) begin
                    r_cnt[i] <= '0;
                end
            end else if (accept) begin
                r_cnt <= n_cnt;
            end
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/faps_queue.sv =====
// Two-entry job queue between the front and back ends.
// Plain flip-flop storage; depends on nothing but the width it is given.
`timescale 1ns / 1ps

module faps_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0]         r_mem [DEPTH];
    logic                     r_wptr;
    logic                     r_rptr;
    logic [$clog2(DEPTH+1)-1:0] r_count;
    logic                     push;
    logic                     pop;

    assign o_push_ready = (r_count != 2'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/faps_back.sv =====
// Back end: three multiply-add stages that fold the target offset, then the result.
// Depends on faps_pkg and faps_if.
`timescale 1ns / 1ps

module faps_back #(
    parameter int MAX_EXTENT = faps_pkg::MAX_EXTENT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  logic [faps_pkg::ELEM_W + 1
                  + faps_pkg::NUM_AXES * faps_pkg::cnt_width(MAX_EXTENT)
                  + (faps_pkg::NUM_AXES - 1) * faps_pkg::ext_width(MAX_EXTENT) - 1:0] i_job,
    faps_out_if.source      o_out
);

    localparam int CW = faps_pkg::cnt_width(MAX_EXTENT);
    localparam int EW = faps_pkg::ext_width(MAX_EXTENT);
    localparam int OW = faps_pkg::OFFS_W;
    localparam int LW = faps_pkg::ELEM_W;

    logic [LW-1:0] j_elem;
    logic          j_last;
    logic [CW-1:0] j_y0, j_y1, j_y2, j_y3;
    logic [EW-1:0] j_m1, j_m2, j_m3;
    logic          adv;

    logic          r_v1, r_v2, r_v3;
    logic [LW-1:0] r_elem1, r_elem2, r_elem3;
    logic          r_last1, r_last2, r_last3;
    logic [OW-1:0] r_acc1, r_acc2, r_acc3;
    logic [CW-1:0] r_y2_1, r_y3_1, r_y3_2;
    logic [EW-1:0] r_m2_1, r_m3_1, r_m3_2;

    assign {j_elem, j_last, j_y0, j_y1, j_y2, j_y3, j_m1, j_m2, j_m3} = i_job;

    // Move the whole pipe unless the result is held
    assign adv         = ~r_v3 | o_out.ready;
    assign o_job_ready = adv;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Fold the first two axes in stage one, then one axis per stage, offset kept modulo 2^OFFS_W
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_acc1  <= OW'(j_y0) * OW'(j_m1) + OW'(j_y1);
            r_elem1 <= j_elem;
            r_last1 <= j_last;
            r_y2_1  <= j_y2;
            r_y3_1  <= j_y3;
            r_m2_1  <= j_m2;
            r_m3_1  <= j_m3;

            r_acc2  <= OW'(r_acc1 * OW'(r_m2_1)) + OW'(r_y2_1);
            r_elem2 <= r_elem1;
            r_last2 <= r_last1;
            r_y3_2  <= r_y3_1;
            r_m3_2  <= r_m3_1;

            r_acc3  <= OW'(r_acc2 * OW'(r_m3_2)) + OW'(r_y3_2);
            r_elem3 <= r_elem2;
            r_last3 <= r_last2;
        end
    end

    assign o_out.valid       = r_v3;
    assign o_out.elem_out    = r_elem3;
    assign o_out.dest_offset = r_acc3;
    assign o_out.is_last     = r_last3;

endmodule

// ===== hdl/four_axis_permute_scatter_core.sv =====
// Top level of the four-axis permute/scatter address generator.
// Depends on faps_pkg, faps_if, faps_front, faps_queue and faps_back.
//
//   port    dir   handshake      payload
//   i_cfg   in    valid/ready    index (3), data (6)
//   i_in    in    valid/ready    elem_in (64)
//   o_out   out   valid/ready    elem_out (64), dest_offset (20), is_last (1)
//
// One item per cycle sustained while results are taken; the front end updates its counters on every accepted item.
// From input accept to the earliest result accept, a job passes through the
// two-entry queue and then the three multiply-add stages in the back end, the last being the
// output register.
// Reset is synchronous, active low; it sets extents to 1, mode to 0, counters to zero.
// A held result stalls the back end; the queue then fills and input ready drops.
// Configuration writes are always taken; an extent write restarts the walk.
`timescale 1ns / 1ps

module four_axis_permute_scatter_core #(
    parameter int MAX_EXTENT = faps_pkg::MAX_EXTENT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    faps_cfg_if.sink  i_cfg,
    faps_in_if.sink   i_in,
    faps_out_if.source o_out
);

    localparam int JOB_W = faps_pkg::ELEM_W + 1
                         + faps_pkg::NUM_AXES * faps_pkg::cnt_width(MAX_EXTENT)
                         + (faps_pkg::NUM_AXES - 1) * faps_pkg::ext_width(MAX_EXTENT);

    logic                  fj_valid;
    logic                  fj_ready;
    logic [JOB_W-1:0]      fj_data;
    logic                  bj_valid;
    logic                  bj_ready;
    logic [JOB_W-1:0]      bj_data;
    faps_pkg::t_front_stat front_stat;

    // Accept items and build jobs
    faps_front #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_in        (i_in),
        .o_job_valid (fj_valid),
        .i_job_ready (fj_ready),
        .o_job       (fj_data),
        .o_stat      (front_stat)
    );

    // Decouple front and back
    faps_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fj_valid),
        .o_push_ready (fj_ready),
        .i_push_data  (fj_data),
        .o_pop_valid  (bj_valid),
        .i_pop_ready  (bj_ready),
        .o_pop_data   (bj_data)
    );

    // Compute offsets and deliver results
    faps_back #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (bj_valid),
        .o_job_ready (bj_ready),
        .i_job       (bj_data),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // An extent write restarts at the first element
    a_ext_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready
         && (i_cfg.index == faps_pkg::REG_EXTENT_ONE
             || i_cfg.index == faps_pkg::REG_EXTENT_TWO
             || i_cfg.index == faps_pkg::REG_EXTENT_THREE
             || i_cfg.index == faps_pkg::REG_EXTENT_FOUR))
        |=> front_stat.at_first)
        else $error("counters not cleared after extent write");

    // Counters wrap after the final element
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && front_stat.at_last) |=> front_stat.at_first)
        else $error("counters did not wrap after final element");

    // A job waiting in the queue is taken whenever no result is held at the output
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bj_valid && !o_out.valid) |-> bj_ready)
        else $error("back end refused a job while empty at output");
`endif

endmodule
